// ===== src/rac_pkg.sv =====
// Shared types and constants for the region access checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package rac_pkg;

	localparam int MAX_REGIONS = 6;
	localparam int APB_ADDR_W  = 6;
	localparam int APB_DATA_W  = 64;
	localparam int BYTE_LANES  = 4;

	typedef enum logic [2:0] {
		KIND_RAM   = 3'd0,
		KIND_ROM   = 3'd1,
		KIND_FLASH = 3'd2,
		KIND_MMIO  = 3'd3,
		KIND_NONE  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		FAULT_OK        = 2'd0,
		FAULT_UNALIGNED = 2'd1,
		FAULT_UNMAPPED  = 2'd2,
		FAULT_READ_ONLY = 2'd3
	} fault_t;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	localparam logic [2:0] NO_REGION = 3'd6;

	localparam logic [2:0] REG_WATCH_RANGE  = 3'd6;
	localparam logic [2:0] REG_WATCH_ENABLE = 3'd7;

	localparam kind_t REGION_KINDS [MAX_REGIONS] = '{
		KIND_RAM, KIND_RAM, KIND_ROM, KIND_FLASH, KIND_FLASH, KIND_MMIO
	};

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
	} region_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] len;
		logic [1:0]  en;
	} watch_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  idx;
		kind_t       kind;
		logic [31:0] base;
		logic        trig;
	} byte_res_t;

	typedef struct packed {
		logic [4:0]  pad;
		logic [1:0]  size_code;
		logic [31:0] address;
		logic        op;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  pad;
		logic [2:0]  watch_hits;
		logic [2:0]  bytes_done;
		logic [31:0] offset;
		logic [2:0]  region_kind;
		logic [2:0]  region_index;
		logic [1:0]  fault;
	} out_item_t;

endpackage

`default_nettype wire

// ===== src/rac_regfile.sv =====
// Configuration registers behind the APB port: region map and watchpoint.
// Depends on rac_pkg.
`default_nettype none

module rac_regfile import rac_pkg::*; #(
	parameter int NUM_REGIONS = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output region_t                    regions [NUM_REGIONS],
	output watch_t                     watch
);

	logic       wr;
	logic [2:0] idx;
	region_t    region_q [NUM_REGIONS];
	watch_t     watch_q;

	assign wr  = psel && penable && pwrite;
	assign idx = paddr[5:3];

	for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_region
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				region_q[g] <= '0;
			end else if (wr && idx == 3'(g)) begin
				region_q[g] <= pwdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_q <= '0;
		end else if (wr) begin
			if (idx == REG_WATCH_RANGE) begin
				watch_q.start <= pwdata[63:32];
				watch_q.len   <= pwdata[31:0];
			end
			if (idx == REG_WATCH_ENABLE) begin
				watch_q.en <= pwdata[1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_WATCH_RANGE: prdata = {watch_q.start, watch_q.len};
			REG_WATCH_ENABLE: prdata = {62'b0, watch_q.en};
			default: begin
				for (int i = 0; i < NUM_REGIONS; i++) begin
					if (idx == 3'(i)) prdata = region_q[i];
				end
			end
		endcase
	end

	assign regions = region_q;
	assign watch   = watch_q;

endmodule

`default_nettype wire

// ===== src/rac_byte_dec.sv =====
// Decode of one byte address: region select, range hit and watchpoint trigger.
// Depends on rac_pkg.
`default_nettype none

module rac_byte_dec import rac_pkg::*; #(
	parameter int NUM_REGIONS = 6
) (
	input  wire logic [31:0] addr,
	input  wire logic        is_write,
	input  wire region_t     regions [NUM_REGIONS],
	input  wire watch_t      watch,
	output byte_res_t        res
);

	logic [NUM_REGIONS-1:0] le;
	logic [NUM_REGIONS-1:0] win;
	logic [31:0]            sel_base;
	logic [31:0]            sel_end;
	logic [2:0]             sel_idx;
	kind_t                  sel_kind;
	logic                   hit;
	logic [31:0]            watch_end;
	logic                   watch_on;

	always_comb begin
		for (int i = 0; i < NUM_REGIONS; i++) begin
			le[i] = regions[i].base <= addr;
		end
		for (int i = 0; i < NUM_REGIONS; i++) begin
			win[i] = le[i];
			for (int j = 0; j < NUM_REGIONS; j++) begin
				if (j < i && le[j] && regions[i].base < regions[j].base) win[i] = 1'b0;
				if (j > i && le[j] && regions[i].base <= regions[j].base) win[i] = 1'b0;
			end
		end
		sel_base = '0;
		sel_end  = '0;
		sel_idx  = NO_REGION;
		sel_kind = KIND_NONE;
		for (int i = 0; i < NUM_REGIONS; i++) begin
			if (win[i]) begin
				sel_base = regions[i].base;
				sel_end  = regions[i].base + regions[i].size;
				sel_idx  = 3'(i);
				sel_kind = REGION_KINDS[i];
			end
		end
		hit = (|win) && (addr < sel_end);
	end

	assign watch_end = watch.start + watch.len;
	assign watch_on  = is_write ? watch.en[1] : watch.en[0];

	always_comb begin
		res.hit  = hit;
		res.idx  = hit ? sel_idx : NO_REGION;
		res.kind = hit ? sel_kind : KIND_NONE;
		res.base = sel_base;
		res.trig = watch_on && addr >= watch.start && addr < watch_end
			&& !(sel_kind == KIND_MMIO && !is_write);
	end

endmodule

`default_nettype wire

// ===== src/region_access_checker.sv =====
// Top level: APB register file, input stage, per-byte decode, result stage.
// Depends on rac_pkg, rac_regfile and rac_byte_dec.
//
// channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | op, address, size_code
// m_*      | out | m_tvalid/m_tready  | fault, region_index, region_kind, offset,
//          |     |                    | bytes_done, watch_hits
// APB      | in  | psel/penable       | paddr, pwdata, prdata
//
// One request per cycle sustained while m_tready stays high; an accepted request passes
// through the input register and then the result register before its result is valid.
// Reset clears the configuration registers and both stage valids.
// A stalled result holds in the result register; s_tready drops only when
// both the input and result stages are full.
`default_nettype none

module region_access_checker import rac_pkg::*; #(
	parameter int NUM_REGIONS = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [39:0]           s_tdata,  // op, address, size_code
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [47:0]           m_tdata,  // fault, region_index, region_kind,
	                                             // offset, bytes_done, watch_hits
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready
);

	region_t   regions [NUM_REGIONS];
	watch_t    watch;
	in_item_t  in_item;
	logic      valid_s1;
	logic      op_s1;
	logic [31:0] addr_s1;
	logic [1:0]  size_s1;
	logic      valid_s2;
	out_item_t res_s2;
	logic      adv_s2;
	byte_res_t lane [BYTE_LANES];
	logic [2:0] nbytes;
	logic       misaligned;
	out_item_t  res_c;
	logic       stop;

	assign pready = 1'b1;

	rac_regfile #(.NUM_REGIONS(NUM_REGIONS)) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.regions (regions),
		.watch   (watch)
	);

	assign in_item  = s_tdata;
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= in_item.op;
			addr_s1 <= in_item.address;
			size_s1 <= in_item.size_code;
		end
	end

	for (genvar b = 0; b < BYTE_LANES; b++) begin : g_lane
		rac_byte_dec #(.NUM_REGIONS(NUM_REGIONS)) u_byte_dec (
			.addr     ({addr_s1[31:2], addr_s1[1:0] | 2'(b)}),
			.is_write (op_s1),
			.regions  (regions),
			.watch    (watch),
			.res      (lane[b])
		);
	end

	always_comb begin
		case (size_s1)
			SIZE_BYTE: nbytes = 3'd1;
			SIZE_HALF: nbytes = 3'd2;
			default:   nbytes = 3'd4;
		endcase
		misaligned = (nbytes == 3'd2 && addr_s1[0]) || (nbytes == 3'd4 && addr_s1[1:0] != 2'b00);

		res_c              = '0;
		res_c.region_index = NO_REGION;
		res_c.region_kind  = KIND_NONE;
		stop               = 1'b0;
		if (misaligned) begin
			res_c.fault = FAULT_UNALIGNED;
		end else begin
			res_c.region_index = lane[0].idx;
			res_c.region_kind  = lane[0].kind;
			res_c.offset       = lane[0].hit ? addr_s1 - lane[0].base : '0;
			for (int b = 0; b < BYTE_LANES; b++) begin
				if (!stop && 3'(b) < nbytes) begin
					if (!lane[b].hit) begin
						res_c.fault = FAULT_UNMAPPED;
						stop        = 1'b1;
					end else if (op_s1 && (lane[b].kind == KIND_ROM
						|| lane[b].kind == KIND_FLASH)) begin
						res_c.fault = FAULT_READ_ONLY;
						stop        = 1'b1;
					end else begin
						res_c.bytes_done = res_c.bytes_done + 3'd1;
						if (lane[b].trig) res_c.watch_hits = res_c.watch_hits + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

endmodule

`default_nettype wire

// ===== src/rac_checker.sv =====
// Port-level assertions for the region access checker, bound to the top level.
// Depends on rac_pkg.
`default_nettype none

module rac_checker import rac_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [47:0]           m_tdata,
	input wire logic                  pready
);

	out_item_t o;

	assign o = m_tdata;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_unaligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o.fault == FAULT_UNALIGNED |->
			o.region_index == NO_REGION && o.bytes_done == 3'd0 && o.watch_hits == 3'd0)
		else $error("unaligned request reported progress");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> o.bytes_done <= 3'd4 && o.watch_hits <= o.bytes_done)
		else $error("byte counts out of range");

	a_ok_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && o.fault == FAULT_OK |->
			o.region_index != NO_REGION && o.bytes_done != 3'd0)
		else $error("clean request without region");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready && pready)
		else $error("input stalled while output empty");

endmodule

bind region_access_checker rac_checker u_rac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);

`default_nettype wire
